/* sv/sbmd_pkg.sv */
// Package for the stereo block-matching depth unit.
// Holds the controller/datapath command and status structs and register codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sbmd_pkg;

	typedef logic signed [11:0] coord_t;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_FEATURE_HALF_W = 3'd2;
	localparam logic [2:0] REG_FEATURE_HALF_H = 3'd3;
	localparam logic [2:0] REG_MAX_DISP      = 3'd4;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
		logic cand_init;
		logic box_step;
		logic disp_step;
		logic update;
		logic sqrt_init;
		logic sqrt_step;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic border;
		logic fits;
		logic box_last;
		logic disp_last;
		logic pipe_busy;
		logic sqrt_last;
	} stat_t;

endpackage
`default_nettype wire

/* sv/sbmd_dp.sv */
// Datapath of the stereo block-matching depth unit: image memories, loop counters,
// squared-difference accumulator, best-candidate tracking and a bit-serial square root.
// Depends on sbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbmd_dp #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_FEATURE = 8,
	parameter int MAX_DISPLACEMENT = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbmd_pkg::cmd_t cmd,
	output sbmd_pkg::stat_t    stat,
	input  wire logic [5:0]    pixel_x,
	input  wire logic [5:0]    pixel_y,
	input  wire logic [7:0]    left_sample,
	input  wire logic [7:0]    right_sample,
	input  wire logic [6:0]    image_width,
	input  wire logic [6:0]    image_height,
	input  wire logic [3:0]    feature_half_width,
	input  wire logic [3:0]    feature_half_height,
	input  wire logic [3:0]    max_disp,
	output logic [11:0]        depth_value,
	output logic [7:0]         best_sq_disp,
	output logic               match_found
);
	import sbmd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(MAX_DISPLACEMENT + 1) + 1;
	localparam int DU = DW - 1;
	localparam int FW = $clog2(MAX_FEATURE + 1) + 1;
	localparam int FU = FW - 1;
	localparam int DSQ_W = $clog2(2 * MAX_DISPLACEMENT * MAX_DISPLACEMENT + 1);
	localparam int SSD_W = $clog2((2 * MAX_FEATURE + 1) * (2 * MAX_FEATURE + 1) * 65025 + 1);
	localparam int SQ_W = 25;

	logic [7:0] left_mem [DEPTH];
	logic [7:0] right_mem [DEPTH];

	coord_t cx_q, cy_q, w_q, h_q;
	logic [FU-1:0] fw_q, fh_q;
	logic [DU-1:0] md_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [FW-1:0] bx_q, by_q;
	logic [SSD_W-1:0] ssd_q, best_ssd_q;
	logic [DSQ_W-1:0] best_dsq_q;
	logic have_q;
	logic v_s1, v_s2;
	logic [7:0] l_s1, r_s1;
	logic [15:0] sq_s2;
	logic [SQ_W-1:0] sq_n_q, sq_root_q, sq_bit_q;

	coord_t fwc, fhc, mdc, dxc, dyc, lx, ly, rx, ry;
	coord_t w_c, h_c;
	logic [FU-1:0] fw_c, fh_c;
	logic [DU-1:0] md_c;
	logic [AW-1:0] laddr, raddr, waddr;
	logic signed [8:0] diff;
	logic signed [17:0] prod;
	logic [DSQ_W-1:0] dsq;
	logic [DW-1:0] dxa, dya;
	logic [SQ_W-1:0] trial, root_fin;
	logic better;

	always_comb begin
		w_c = coord_t'({5'b0, image_width});
		if (image_width == 7'd0) w_c = coord_t'(1);
		else if (int'(image_width) > MAX_WIDTH) w_c = coord_t'(MAX_WIDTH);
		h_c = coord_t'({5'b0, image_height});
		if (image_height == 7'd0) h_c = coord_t'(1);
		else if (int'(image_height) > MAX_HEIGHT) h_c = coord_t'(MAX_HEIGHT);
		fw_c = (int'(feature_half_width) > MAX_FEATURE) ? FU'(MAX_FEATURE) : FU'(feature_half_width);
		fh_c = (int'(feature_half_height) > MAX_FEATURE) ? FU'(MAX_FEATURE) : FU'(feature_half_height);
		md_c = (int'(max_disp) > MAX_DISPLACEMENT) ? DU'(MAX_DISPLACEMENT) : DU'(max_disp);
	end

	assign fwc = coord_t'(signed'({1'b0, fw_q}));
	assign fhc = coord_t'(signed'({1'b0, fh_q}));
	assign mdc = coord_t'(signed'({1'b0, md_q}));
	assign dxc = coord_t'(dx_q);
	assign dyc = coord_t'(dy_q);
	assign lx = cx_q + coord_t'(bx_q);
	assign ly = cy_q + coord_t'(by_q);
	assign rx = lx + dxc;
	assign ry = ly + dyc;
	assign laddr = AW'(AW'(ly) * AW'(MAX_WIDTH) + AW'(lx));
	assign raddr = AW'(AW'(ry) * AW'(MAX_WIDTH) + AW'(rx));
	assign waddr = AW'(AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x));

	assign stat.border = (cy_q < fhc) || (cy_q >= h_q - fhc) || (cx_q < fwc) || (cx_q >= w_q - fwc);
	assign stat.fits = (cy_q + dyc - fhc >= 0) && (cy_q + dyc + fhc < h_q) &&
		(cx_q + dxc - fwc >= 0) && (cx_q + dxc + fwc < w_q);
	assign stat.box_last = (coord_t'(bx_q) == fwc) && (coord_t'(by_q) == fhc);
	assign stat.disp_last = (dxc == mdc) && (dyc == mdc);
	assign stat.pipe_busy = v_s1 | v_s2;
	assign stat.sqrt_last = sq_bit_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load && int'(pixel_x) < MAX_WIDTH && int'(pixel_y) < MAX_HEIGHT) begin
			left_mem[waddr] <= left_sample;
			right_mem[waddr] <= right_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.box_step) begin
			l_s1 <= left_mem[laddr];
			r_s1 <= right_mem[raddr];
		end
	end

	assign diff = signed'({1'b0, l_s1}) - signed'({1'b0, r_s1});
	assign prod = diff * diff;
	assign dxa = dx_q[DW-1] ? -dx_q : dx_q;
	assign dya = dy_q[DW-1] ? -dy_q : dy_q;
	assign dsq = DSQ_W'(dxa) * DSQ_W'(dxa) + DSQ_W'(dya) * DSQ_W'(dya);
	assign better = !have_q || (ssd_q < best_ssd_q) || (ssd_q == best_ssd_q && dsq < best_dsq_q);
	assign trial = sq_root_q + sq_bit_q;
	assign root_fin = (sq_n_q > sq_root_q) ? sq_root_q + SQ_W'(1) : sq_root_q;

	always_ff @(posedge clk) begin
		sq_s2 <= prod[15:0];
		if (cmd.start) begin
			cx_q <= coord_t'({6'b0, pixel_x});
			cy_q <= coord_t'({6'b0, pixel_y});
			w_q <= w_c;
			h_q <= h_c;
			fw_q <= fw_c;
			fh_q <= fh_c;
			md_q <= md_c;
			dx_q <= -DW'(signed'({1'b0, md_c}));
			dy_q <= -DW'(signed'({1'b0, md_c}));
		end
		if (cmd.disp_step) begin
			if (dxc == mdc) begin
				dx_q <= -DW'(signed'({1'b0, md_q}));
				dy_q <= dy_q + DW'(1);
			end else begin
				dx_q <= dx_q + DW'(1);
			end
		end
		if (cmd.cand_init) begin
			bx_q <= -FW'(signed'({1'b0, fw_q}));
			by_q <= -FW'(signed'({1'b0, fh_q}));
		end
		if (cmd.box_step) begin
			if (coord_t'(bx_q) == fwc) begin
				bx_q <= -FW'(signed'({1'b0, fw_q}));
				by_q <= by_q + FW'(1);
			end else begin
				bx_q <= bx_q + FW'(1);
			end
		end
		if (cmd.cand_init) begin
			ssd_q <= '0;
		end else if (v_s2) begin
			ssd_q <= ssd_q + SSD_W'(sq_s2);
		end
		if (cmd.sqrt_init) begin
			sq_n_q <= SQ_W'({8'(best_dsq_q), 16'b0});
			sq_root_q <= '0;
			sq_bit_q <= SQ_W'(1) << 22;
		end else if (cmd.sqrt_step) begin
			if (sq_n_q >= trial) begin
				sq_n_q <= sq_n_q - trial;
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.result) begin
			best_sq_disp <= 8'(best_dsq_q);
			match_found <= have_q;
			if (!have_q || md_q == '0) depth_value <= '0;
			else if (int'(best_dsq_q) > 255) depth_value <= 12'd4095;
			else depth_value <= 12'(root_fin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			have_q <= 1'b0;
			best_ssd_q <= '0;
			best_dsq_q <= '0;
		end else begin
			v_s1 <= cmd.box_step;
			v_s2 <= v_s1;
			if (cmd.start) begin
				have_q <= 1'b0;
				best_ssd_q <= '0;
				best_dsq_q <= '0;
			end else if (cmd.update && better) begin
				have_q <= 1'b1;
				best_ssd_q <= ssd_q;
				best_dsq_q <= dsq;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/sbmd_ctrl.sv */
// Controller of the stereo block-matching depth unit: sequences loads, the
// displacement and box loops, the square root and the result handshake. Depends on sbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbmd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           op,
	output logic                out_valid,
	input  wire logic           out_stall,
	output sbmd_pkg::cmd_t      cmd,
	input  wire sbmd_pkg::stat_t stat
);
	import sbmd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_CAND  = 4'd2;
	localparam logic [3:0] ST_BOX   = 4'd3;
	localparam logic [3:0] ST_DRAIN = 4'd4;
	localparam logic [3:0] ST_NEXT  = 4'd5;
	localparam logic [3:0] ST_FIN   = 4'd6;
	localparam logic [3:0] ST_SQRT  = 4'd7;
	localparam logic [3:0] ST_RES   = 4'd8;

	logic [3:0] state_q, state_d;
	logic out_valid_q;
	logic in_acc, can_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (op == OP_COMPUTE) begin
						cmd.start = 1'b1;
						state_d = ST_CHECK;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_CHECK: state_d = stat.border ? ST_FIN : ST_CAND;
			ST_CAND: begin
				if (stat.fits) begin
					cmd.cand_init = 1'b1;
					state_d = ST_BOX;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_BOX: begin
				cmd.box_step = 1'b1;
				if (stat.box_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.update = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (stat.disp_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.disp_step = 1'b1;
					state_d = ST_CAND;
				end
			end
			ST_FIN: begin
				cmd.sqrt_init = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last) state_d = ST_RES;
			end
			ST_RES: begin
				if (can_load) begin
					cmd.result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_update_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !stat.pipe_busy) else $error("candidate compared before sum finished");
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> !(out_valid_q && out_stall)) else $error("result overwrote pending output");
	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_COMPUTE) |=> (state_q == ST_CHECK)) else $error("compute not started");
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");

endmodule
`default_nettype wire

/* sv/stereo_block_match_depth.sv */
// Top level of the stereo block-matching depth unit: configuration registers,
// controller and datapath. Depends on sbmd_pkg, sbmd_ctrl and sbmd_dp.
//
// A load transaction writes one left/right pixel pair. A compute transaction
// passes a border check and, away from the border, tries every displacement in
// the search square; each fitting candidate is summed over its feature box and
// each rejected one is skipped, after which a setup state, a bit-serial square
// root and a result state follow. The run time is set by the single read port of
// each image memory, which delivers one pixel pair per cycle to the sum-of-squares
// loop. A finished result waits in an output register while the next transaction
// is taken in. Configuration is to be written by the user through the APB port
// while the unit is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module stereo_block_match_depth #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_FEATURE = 8,
	parameter int MAX_DISPLACEMENT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [5:0]  pixel_x,
	input  wire logic [5:0]  pixel_y,
	input  wire logic [7:0]  left_sample,
	input  wire logic [7:0]  right_sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      depth_value,
	output logic [7:0]       best_sq_disp,
	output logic             match_found
);
	import sbmd_pkg::*;

	logic [6:0] image_width_q, image_height_q;
	logic [3:0] feature_half_width_q, feature_half_height_q, max_disp_q;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 7'd64;
			image_height_q <= 7'd64;
			feature_half_width_q <= 4'd2;
			feature_half_height_q <= 4'd2;
			max_disp_q <= 4'd4;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_IMAGE_WIDTH:    image_width_q <= pwdata[6:0];
				REG_IMAGE_HEIGHT:   image_height_q <= pwdata[6:0];
				REG_FEATURE_HALF_W: feature_half_width_q <= pwdata[3:0];
				REG_FEATURE_HALF_H: feature_half_height_q <= pwdata[3:0];
				REG_MAX_DISP:       max_disp_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_IMAGE_WIDTH:    prdata = {25'b0, image_width_q};
			REG_IMAGE_HEIGHT:   prdata = {25'b0, image_height_q};
			REG_FEATURE_HALF_W: prdata = {28'b0, feature_half_width_q};
			REG_FEATURE_HALF_H: prdata = {28'b0, feature_half_height_q};
			REG_MAX_DISP:       prdata = {28'b0, max_disp_q};
			default:            prdata = '0;
		endcase
	end

	sbmd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.stat(stat)
	);

	sbmd_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_FEATURE(MAX_FEATURE),
		.MAX_DISPLACEMENT(MAX_DISPLACEMENT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.feature_half_width(feature_half_width_q),
		.feature_half_height(feature_half_height_q),
		.max_disp(max_disp_q),
		.depth_value(depth_value),
		.best_sq_disp(best_sq_disp),
		.match_found(match_found)
	);

endmodule
`default_nettype wire

/* tb/tb_stereo_block_match_depth.sv */
// Testbench for the stereo block-matching depth unit: a scoreboard class predicts
// the depth result of every accepted compute transaction and checks the outputs.
// Depends on sbmd_pkg and stereo_block_match_depth.
`timescale 1ns / 1ps
`default_nettype none
module tb_stereo_block_match_depth;
	import sbmd_pkg::*;

	typedef struct {
		logic [11:0] depth;
		logic [7:0]  sq_disp;
		logic        found;
	} depth_result_t;

	class depth_scoreboard;
		logic [7:0] left_pix[4096];
		logic [7:0] right_pix[4096];
		logic [6:0] img_w = 7'd64;
		logic [6:0] img_h = 7'd64;
		logic [3:0] half_w = 4'd2;
		logic [3:0] half_h = 4'd2;
		logic [3:0] search = 4'd4;
		depth_result_t pending[$];
		int errors = 0;

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_IMAGE_WIDTH: img_w = val[6:0];
				REG_IMAGE_HEIGHT: img_h = val[6:0];
				REG_FEATURE_HALF_W: half_w = val[3:0];
				REG_FEATURE_HALF_H: half_h = val[3:0];
				REG_MAX_DISP: search = val[3:0];
				default: ;
			endcase
		endfunction

		function logic [11:0] fixed_root(int unsigned s);
			int unsigned n, r;
			n = s << 16;
			r = 0;
			for (int b = 11; b >= 0; b--)
				if ((r | (1 << b)) * (r | (1 << b)) <= n)
					r = r | (1 << b);
			if (n - r * r > r)
				r++;
			return (r > 4095) ? 12'd4095 : r[11:0];
		endfunction

		function void note_input(logic o, int x, int y, logic [7:0] l, logic [7:0] r);
			int w, h, fw, fh, md, dsq, ld, rd;
			int unsigned ssd, best_ssd;
			depth_result_t res;
			if (o == OP_LOAD) begin
				left_pix[y * 64 + x] = l;
				right_pix[y * 64 + x] = r;
				return;
			end
			w = (img_w < 1) ? 1 : (img_w > 64) ? 64 : img_w;
			h = (img_h < 1) ? 1 : (img_h > 64) ? 64 : img_h;
			fw = (half_w > 8) ? 8 : half_w;
			fh = (half_h > 8) ? 8 : half_h;
			md = (search > 8) ? 8 : search;
			res.depth = '0;
			res.sq_disp = '0;
			res.found = 1'b0;
			best_ssd = 0;
			if (!(y < fh || y >= h - fh || x < fw || x >= w - fw)) begin
				for (int dy = -md; dy <= md; dy++)
					for (int dx = -md; dx <= md; dx++) begin
						if (y + dy - fh < 0 || y + dy + fh >= h || x + dx - fw < 0 ||
								x + dx + fw >= w)
							continue;
						ssd = 0;
						for (int by = -fh; by <= fh; by++)
							for (int bx = -fw; bx <= fw; bx++) begin
								ld = left_pix[(y + by) * 64 + x + bx];
								rd = right_pix[(y + dy + by) * 64 + x + dx + bx];
								ssd += (ld - rd) * (ld - rd);
							end
						dsq = dx * dx + dy * dy;
						if (!res.found || ssd < best_ssd ||
								(ssd == best_ssd && dsq < res.sq_disp)) begin
							best_ssd = ssd;
							res.sq_disp = dsq[7:0];
							res.found = 1'b1;
						end
					end
			end
			if (res.found && md != 0)
				res.depth = fixed_root(res.sq_disp);
			pending.push_back(res);
		endfunction

		function void check_result(logic [11:0] d, logic [7:0] s, logic m);
			depth_result_t exp_res;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result depth=%0d sq=%0d found=%0d", $time, d, s, m);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (d !== exp_res.depth) begin
				$display("%0t: depth_value expected %0d actual %0d", $time, exp_res.depth, d);
				errors++;
			end
			if (s !== exp_res.sq_disp) begin
				$display("%0t: best_sq_disp expected %0d actual %0d", $time, exp_res.sq_disp, s);
				errors++;
			end
			if (m !== exp_res.found) begin
				$display("%0t: match_found expected %0d actual %0d", $time, exp_res.found, m);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, op;
	logic [5:0] pixel_x, pixel_y;
	logic [7:0] left_sample, right_sample;
	logic out_valid, out_stall;
	logic [11:0] depth_value;
	logic [7:0] best_sq_disp;
	logic match_found;

	depth_scoreboard sb = new();
	bit loaded[4096];
	int cur_w = 64, cur_h = 64, cur_fw = 2, cur_fh = 2, cur_md = 4;
	bit no_gaps = 0;
	bit hold_request = 0;
	int idle_cycles = 0;

	stereo_block_match_depth dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(depth_value, best_sq_disp, match_found);
				stall_left = no_gaps ? 0 : $urandom_range(0, 9);
			end
			if (hold_request) begin
				hold_request = 0;
				stall_left = 400;
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 500000) begin
				$display("stereo_block_match_depth: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, val);
		case (idx)
			REG_IMAGE_WIDTH: cur_w = (val[6:0] < 1) ? 1 : (val[6:0] > 64) ? 64 : val[6:0];
			REG_IMAGE_HEIGHT: cur_h = (val[6:0] < 1) ? 1 : (val[6:0] > 64) ? 64 : val[6:0];
			REG_FEATURE_HALF_W: cur_fw = (val[3:0] > 8) ? 8 : val[3:0];
			REG_FEATURE_HALF_H: cur_fh = (val[3:0] > 8) ? 8 : val[3:0];
			REG_MAX_DISP: cur_md = (val[3:0] > 8) ? 8 : val[3:0];
			default: ;
		endcase
	endtask

	task automatic configure(int w, int h, int fw, int fh, int md);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_FEATURE_HALF_W, fw);
		write_reg(REG_FEATURE_HALF_H, fh);
		write_reg(REG_MAX_DISP, md);
	endtask

	task automatic send(logic o, int x, int y, logic [7:0] l, logic [7:0] r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		pixel_x <= 6'(x);
		pixel_y <= 6'(y);
		left_sample <= l;
		right_sample <= r;
		do @(posedge clk); while (in_stall);
		sb.note_input(o, x, y, l, r);
		if (o == OP_LOAD)
			loaded[y * 64 + x] = 1;
	endtask

	task automatic load_pixel(int x, int y);
		send(OP_LOAD, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// Every image entry a compute may read is loaded before the compute goes out.
	task automatic compute(int x, int y);
		int x0, x1, y0, y1;
		if (!(y < cur_fh || y >= cur_h - cur_fh || x < cur_fw || x >= cur_w - cur_fw)) begin
			x0 = (x - cur_md - cur_fw < 0) ? 0 : x - cur_md - cur_fw;
			x1 = (x + cur_md + cur_fw > cur_w - 1) ? cur_w - 1 : x + cur_md + cur_fw;
			y0 = (y - cur_md - cur_fh < 0) ? 0 : y - cur_md - cur_fh;
			y1 = (y + cur_md + cur_fh > cur_h - 1) ? cur_h - 1 : y + cur_md + cur_fh;
			for (int yy = y0; yy <= y1; yy++)
				for (int xx = x0; xx <= x1; xx++)
					if (!loaded[yy * 64 + xx])
						load_pixel(xx, yy);
		end
		send(OP_COMPUTE, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int w, h, md;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = OP_LOAD;
		pixel_x = '0;
		pixel_y = '0;
		left_sample = '0;
		right_sample = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(6, 6, 1, 1, 2);
		for (int yy = 0; yy < 6; yy++)
			for (int xx = 0; xx < 6; xx++)
				send(OP_LOAD, xx, yy, 8'd128, 8'd128);
		compute(3, 3);
		compute(0, 0);
		compute(5, 5);
		compute(63, 63);
		send(OP_LOAD, 2, 2, 8'd255, 8'd0);
		send(OP_LOAD, 63, 63, 8'd0, 8'd255);
		compute(2, 3);
		drain();
		write_reg(REG_MAX_DISP, 0);
		compute(3, 3);
		drain();
		configure(0, 127, 0, 15, 15);
		compute(0, 0);
		compute(0, 63);
		drain();
		configure(17, 1, 0, 0, 8);
		compute(8, 0);
		drain();
		configure(1, 17, 0, 8, 1);
		compute(0, 8);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			w = $urandom_range(2, 6);
			h = $urandom_range(2, 6);
			md = (phase == 3) ? 1 : $urandom_range(0, 3);
			configure(w, h, $urandom_range(0, 1), $urandom_range(0, 1), md);
			no_gaps = (phase == 2);
			if (phase == 3) begin
				no_gaps = 1;
				hold_request = 1;
			end
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(0, 3) == 0)
					load_pixel($urandom_range(0, 63), $urandom_range(0, 63));
				else if ($urandom_range(0, 5) == 0)
					compute($urandom_range(0, 63), $urandom_range(0, 63));
				else
					compute($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
			end
			no_gaps = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("stereo_block_match_depth: match");
		end else begin
			$display("stereo_block_match_depth: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
